[hw/rtl/column_index_compactor_macros.svh]
// Assertion macros for the column index compactor.
// Used by column_index_compactor.sv; expects clk and rst in scope.
`ifndef COLUMN_INDEX_COMPACTOR_MACROS_SVH
`define COLUMN_INDEX_COMPACTOR_MACROS_SVH

// Condition implies consequence in the same cycle.
`define CIC_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("column_index_compactor: check failed");

// Condition implies consequence in the next cycle.
`define CIC_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("column_index_compactor: check failed");

`endif

[hw/rtl/cic_pkg.sv]
// Shared types and constants for the column index compactor.
// No dependencies; used by cic_ctrl, the top level and the bench.
`default_nettype none
package cic_pkg;

  localparam int COLUMN_BITS = 16;
  localparam int COL_FIELD_W = 16;
  localparam int ID_W        = 16;
  localparam int COUNT_W     = 17;

  typedef logic [COLUMN_BITS-1:0] col_addr_t;
  typedef logic [ID_W-1:0]        id_t;
  typedef logic [COUNT_W-1:0]     count_t;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LEARN = 2'd1;
  localparam logic [1:0] REQ_ALIAS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [COL_FIELD_W-1:0] column_index;
    logic                   last_entry;
  } req_t;

  typedef struct packed {
    id_t        compact_id;
    logic       first_seen;
    logic [1:0] status;
    count_t     unique_count;
    logic       last_result;
  } rsp_t;

  typedef struct packed {
    logic      ren;
    col_addr_t raddr;
    logic      wen;
    col_addr_t waddr;
    id_t       wdata;
  } map_port_t;

  typedef struct packed {
    logic      ren;
    id_t       raddr;
    logic      wen;
    id_t       waddr;
    col_addr_t wdata;
  } back_port_t;

endpackage
`default_nettype wire

[hw/rtl/column_index_compactor.sv]
// Top level of the column index compactor: two stores, sequencer, result register.
// Depends on cic_pkg, cic_ram, cic_ctrl and column_index_compactor_macros.svh.
//
// Requests enter on req_valid/req_ready with req_data (clear, learn, alias).
// Each request yields one result on rsp_valid/rsp_ready with rsp_data.
// A request is taken only while the sequencer is idle, so each one is finished
// before the next: one read of the column-to-id store, a dependent read of the
// id-to-column store, then the decide/write step that loads the result register.
// An entry counts as mapped only when its id is below the unique count and
// the id-to-column store points back at the same column, so clear is
// just a reset of the count and no clearing pass is needed.
// Reset (rst, synchronous) zeroes the count and empties the result register;
// store contents are left as they are.
// A result waiting in the output register does not block the next request;
// when the receiver stalls with a result still held, the sequencer holds
// its finished request in the decide cycle until the register frees up.
`default_nettype none
`include "column_index_compactor_macros.svh"
module column_index_compactor (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cic_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output cic_pkg::rsp_t      rsp_data
);

  logic                core_valid;
  logic                core_ready;
  cic_pkg::rsp_t       core_data;
  cic_pkg::map_port_t  map_port;
  cic_pkg::back_port_t back_port;
  cic_pkg::id_t        map_rdata;
  cic_pkg::col_addr_t  back_rdata;

  cic_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .core_valid (core_valid),
    .core_ready (core_ready),
    .core_data  (core_data),
    .map_port   (map_port),
    .map_rdata  (map_rdata),
    .back_port  (back_port),
    .back_rdata (back_rdata)
  );

  cic_ram #(
    .ADDR_W (cic_pkg::COLUMN_BITS),
    .DATA_W (cic_pkg::ID_W)
  ) u_map_ram (
    .clk   (clk),
    .wen   (map_port.wen),
    .waddr (map_port.waddr),
    .wdata (map_port.wdata),
    .ren   (map_port.ren),
    .raddr (map_port.raddr),
    .rdata (map_rdata)
  );

  cic_ram #(
    .ADDR_W (cic_pkg::ID_W),
    .DATA_W (cic_pkg::COLUMN_BITS)
  ) u_back_ram (
    .clk   (clk),
    .wen   (back_port.wen),
    .waddr (back_port.waddr),
    .wdata (back_port.wdata),
    .ren   (back_port.ren),
    .raddr (back_port.raddr),
    .rdata (back_rdata)
  );

  assign core_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_valid && core_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      rsp_data <= core_data;
    end
  end

  `CIC_ASSERT_NEXT(a_busy_after_request, req_valid && req_ready, !req_ready)
  `CIC_ASSERT_NOW(a_count_range, rsp_valid, rsp_data.unique_count <= 17'd65536)
  `CIC_ASSERT_NOW(a_fresh_is_newest, rsp_valid && rsp_data.first_seen,
    rsp_data.status == cic_pkg::ST_OK
    && (17'(rsp_data.compact_id) + 17'd1) == rsp_data.unique_count)
  `CIC_ASSERT_NOW(a_missing_is_empty, rsp_valid && rsp_data.status == cic_pkg::ST_MISSING,
    rsp_data.compact_id == 16'd0 && !rsp_data.first_seen)

endmodule
`default_nettype wire

[hw/rtl/cic_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module cic_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              wen,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              ren,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cic_ctrl.sv]
// Lookup sequencer: reads the column-to-id and id-to-column stores, decides
// the result and writes back new entries. Depends on cic_pkg.
`default_nettype none
module cic_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire cic_pkg::req_t      req_data,
  output logic                    core_valid,
  input  wire logic               core_ready,
  output cic_pkg::rsp_t           core_data,
  output cic_pkg::map_port_t      map_port,
  input  wire cic_pkg::id_t       map_rdata,
  output cic_pkg::back_port_t     back_port,
  input  wire cic_pkg::col_addr_t back_rdata
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t             state;
  cic_pkg::req_t      req_q;
  cic_pkg::count_t    count;
  cic_pkg::count_t    count_next;
  cic_pkg::col_addr_t col_addr;
  logic               in_space;
  logic               hit;
  logic               insert;
  logic               fire;

  assign req_ready = (state == S_IDLE);
  assign col_addr  = cic_pkg::col_addr_t'(req_q.column_index);
  assign in_space  = ((32'(req_q.column_index) >> cic_pkg::COLUMN_BITS) == 32'd0);
  assign hit       = in_space && (cic_pkg::count_t'(map_rdata) < count)
                     && (back_rdata == col_addr);
  assign core_valid = (state == S_DECIDE);
  assign fire       = core_valid && core_ready;

  always_comb begin
    core_data             = '0;
    core_data.last_result = req_q.last_entry;
    insert                = 1'b0;
    count_next            = count;
    case (req_q.req_type)
      cic_pkg::REQ_CLEAR: begin
        count_next = '0;
      end
      cic_pkg::REQ_LEARN: begin
        if (!in_space) begin
          core_data.status = cic_pkg::ST_FULL;
        end else if (hit) begin
          core_data.compact_id = map_rdata;
        end else if (count[cic_pkg::COUNT_W-1]) begin
          core_data.status = cic_pkg::ST_FULL;
        end else begin
          insert               = 1'b1;
          core_data.compact_id = cic_pkg::id_t'(count);
          core_data.first_seen = 1'b1;
          count_next           = count + cic_pkg::count_t'(1);
        end
      end
      cic_pkg::REQ_ALIAS: begin
        if (hit) begin
          core_data.compact_id = map_rdata;
        end else begin
          core_data.status = cic_pkg::ST_MISSING;
        end
      end
      default: begin
      end
    endcase
    core_data.unique_count = count_next;
  end

  always_comb begin
    map_port.ren    = req_valid && req_ready;
    map_port.raddr  = cic_pkg::col_addr_t'(req_data.column_index);
    map_port.wen    = fire && insert;
    map_port.waddr  = col_addr;
    map_port.wdata  = cic_pkg::id_t'(count);
    back_port.ren   = (state == S_LOOK);
    back_port.raddr = map_rdata;
    back_port.wen   = fire && insert;
    back_port.waddr = cic_pkg::id_t'(count);
    back_port.wdata = col_addr;
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (core_ready) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for column_index_compactor: learn, alias, clear and unused-type requests
// against an in-bench model of the column-to-id map. Depends on cic_pkg and the RTL.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES = 12;
  localparam int unsigned COLUMN_SPACE = 1 << cic_pkg::COLUMN_BITS;
  localparam int unsigned ID_LIMIT     = 65536;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          TAIL_CYCLES  = 12;
  localparam longint      CYCLE_LIMIT  = 4_000_000;
  localparam int          RANDOM_ITEMS = 1450;
  localparam int unsigned FILL_COLUMNS = 256;
  localparam int          MAX_PRINTS   = 40;
  localparam int          LONG_HOLD    = 120;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  cic_pkg::req_t req_data  = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  cic_pkg::rsp_t rsp_data;

  int unsigned   col_gen [COLUMN_SPACE];
  cic_pkg::id_t  col_dense_id [COLUMN_SPACE];
  int unsigned   map_gen = 1;
  int unsigned   mapped_count = 0;
  cic_pkg::rsp_t pending_rsp [$];

  bit          steady = 1'b0;
  int          rsp_hold_left = 0;
  int          rsp_wait = 0;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned rsp_checked = 0;
  int unsigned fresh_count = 0;
  int unsigned missing_count = 0;
  longint      cycle_count = 0;

  always #6ns clk = ~clk;

  column_index_compactor i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  function automatic cic_pkg::rsp_t predict_rsp(cic_pkg::req_t r);
    cic_pkg::rsp_t o;
    int unsigned   c;
    bit            in_space;
    o = '0;
    c = 32'(r.column_index);
    in_space = c < COLUMN_SPACE;
    o.last_result = r.last_entry;
    o.status = cic_pkg::ST_OK;
    case (r.req_type)
      cic_pkg::REQ_CLEAR: begin
        map_gen++;
        mapped_count = 0;
      end
      cic_pkg::REQ_LEARN: begin
        if (!in_space) begin
          o.status = cic_pkg::ST_FULL;
        end else if (col_gen[c] == map_gen) begin
          o.compact_id = col_dense_id[c];
        end else if (mapped_count >= ID_LIMIT) begin
          o.status = cic_pkg::ST_FULL;
        end else begin
          col_gen[c] = map_gen;
          col_dense_id[c] = cic_pkg::id_t'(mapped_count);
          o.compact_id = cic_pkg::id_t'(mapped_count);
          o.first_seen = 1'b1;
          mapped_count++;
        end
      end
      cic_pkg::REQ_ALIAS: begin
        if (in_space && col_gen[c] == map_gen) begin
          o.compact_id = col_dense_id[c];
        end else begin
          o.status = cic_pkg::ST_MISSING;
        end
      end
      default: ;
    endcase
    o.unique_count = cic_pkg::count_t'(mapped_count);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch on %s: got %0h, expected %0h (result %0d)",
               what, got, want, rsp_checked);
    err_count++;
  endtask

  task automatic check_rsp(input cic_pkg::rsp_t got);
    cic_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      report_mismatch("result with no request pending", 32'(got.compact_id), 32'd0);
      return;
    end
    want = pending_rsp.pop_front();
    rsp_checked++;
    if (got.compact_id !== want.compact_id)
      report_mismatch("compact_id", 32'(got.compact_id), 32'(want.compact_id));
    if (got.first_seen !== want.first_seen)
      report_mismatch("first_seen", 32'(got.first_seen), 32'(want.first_seen));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.unique_count !== want.unique_count)
      report_mismatch("unique_count", 32'(got.unique_count), 32'(want.unique_count));
    if (got.last_result !== want.last_result)
      report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
    if (want.first_seen)
      fresh_count++;
    if (want.status == cic_pkg::ST_MISSING)
      missing_count++;
  endtask

  // hold ready low for a random wait after each result, or for a long requested hold
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        check_rsp(rsp_data);
        rsp_wait = steady ? 0 : $urandom_range(0, 4);
      end
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] kind,
                          input logic [cic_pkg::COL_FIELD_W-1:0] col,
                          input logic last);
    cic_pkg::req_t r;
    int            gap;
    r.req_type = kind;
    r.column_index = col;
    r.last_entry = last;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_data <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(predict_rsp(r));
    items_sent++;
  endtask

  task automatic wait_results_done();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_req(cic_pkg::REQ_ALIAS, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'hFFFF, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_ALIAS, 16'hFFFF, 1'b0);
    send_req(cic_pkg::REQ_ALIAS, 16'h5555, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'h5555, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'hAAAA, 1'b1);
    send_req(cic_pkg::REQ_ALIAS, 16'hAAAA, 1'b1);
    send_req(REQ_UNUSED, 16'hFFFF, 1'b1);
    send_req(REQ_UNUSED, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_CLEAR, 16'hFFFF, 1'b1);
    send_req(cic_pkg::REQ_ALIAS, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_ALIAS, 16'hFFFF, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'hFFFF, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'h5555, 1'b0);
    send_req(cic_pkg::REQ_ALIAS, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_ALIAS, 16'h5555, 1'b1);
    send_req(cic_pkg::REQ_CLEAR, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_CLEAR, 16'h1234, 1'b0);
    send_req(REQ_UNUSED, 16'hAAAA, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'h0001, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [cic_pkg::COL_FIELD_W-1:0] pool [$];
    logic [cic_pkg::COL_FIELD_W-1:0] base;
    logic [cic_pkg::COL_FIELD_W-1:0] col;
    int                              n_pool;
    int                              n_learn;
    int                              n_alias;
    int unsigned                     target;
    bit                              clustered;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0)
        send_req(cic_pkg::REQ_CLEAR, 16'($urandom), 1'($urandom));
      pool.delete();
      n_pool = $urandom_range(1, 40);
      base = 16'($urandom);
      clustered = $urandom_range(0, 1);
      repeat (n_pool)
        pool.push_back(clustered ? base + 16'($urandom_range(0, 63)) : 16'($urandom));
      n_learn = $urandom_range(1, 60);
      for (int i = 0; i < n_learn; i++)
        send_req(cic_pkg::REQ_LEARN, pool[$urandom_range(0, n_pool - 1)], i == n_learn - 1);
      n_alias = $urandom_range(0, 40);
      for (int i = 0; i < n_alias; i++) begin
        col = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pool[$urandom_range(0, n_pool - 1)];
        send_req(cic_pkg::REQ_ALIAS, col, i == n_alias - 1);
      end
      repeat ($urandom_range(0, 3))
        send_req(2'($urandom), 16'($urandom), 1'($urandom));
    end
    steady = 1'b0;
  endtask

  task automatic test_receiver_stall();
    rsp_hold_left = LONG_HOLD;
    repeat (40) send_req($urandom_range(0, 3) == 0 ? cic_pkg::REQ_ALIAS : cic_pkg::REQ_LEARN,
                         16'($urandom_range(0, 31)), 1'($urandom));
    wait_results_done();
  endtask

  task automatic test_idle_pause();
    repeat (4) begin
      repeat ($urandom_range(1, 8))
        send_req($urandom_range(0, 1) ? cic_pkg::REQ_ALIAS : cic_pkg::REQ_LEARN,
                 16'($urandom_range(0, 15)), 1'($urandom));
      wait_results_done();
    end
  endtask

  task automatic test_fill_map();
    send_req(cic_pkg::REQ_CLEAR, 16'h0000, 1'b0);
    // odd stride gives distinct columns
    for (int unsigned i = 0; i < FILL_COLUMNS; i++)
      send_req(cic_pkg::REQ_LEARN, 16'(i * 40503 + 7), i == FILL_COLUMNS - 1);
    send_req(cic_pkg::REQ_LEARN, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'hFFFF, 1'b0);
    repeat (8) send_req(cic_pkg::REQ_ALIAS, 16'($urandom), 1'b0);
    send_req(REQ_UNUSED, 16'h0000, 1'b1);
    send_req(cic_pkg::REQ_CLEAR, 16'h0000, 1'b0);
    send_req(cic_pkg::REQ_ALIAS, 16'h0007, 1'b0);
    send_req(cic_pkg::REQ_LEARN, 16'h0007, 1'b1);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_streams();
    test_receiver_stall();
    test_idle_pause();
    test_fill_map();
    wait_results_done();
    $display("%0d requests sent, %0d results checked, %0d new columns, %0d alias misses.",
             items_sent, rsp_checked, fresh_count, missing_count);
    $display("Ran corner requests, random learn/alias streams, a long output stall, %s",
             "idle pauses and a long run of distinct columns.");
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
